>>> src/a2u_pkg.sv
// Shared types, character codes and helper functions of the ASCII to unsigned parser.
package a2u_pkg;

   // Parse phase of the current string
   typedef enum logic [2:0] {
      PH_SPACE  = 3'd0,
      PH_START  = 3'd1,
      PH_ZERO   = 3'd2,
      PH_DIGITS = 3'd3,
      PH_DONE   = 3'd4,
      PH_BAD    = 3'd5
   } phase_type;

   // Status flags that travel with a result
   typedef struct packed {
      logic overflow;
      logic bad_base;
      logic digits_found;
   } flags_type;

   localparam int OFFSET_W = 13;
   localparam int RADIX_W  = 6;

   // Register map (byte address / 4)
   localparam logic REG_RADIX = 1'b0;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

   // Bases
   localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
   localparam logic [RADIX_W-1:0] BASE_MIN  = 6'd2;
   localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
   localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
   localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;
   localparam logic [RADIX_W-1:0] BASE_MAX  = 6'd36;
   localparam logic [RADIX_W-1:0] NOT_DIGIT = 6'd63;

   // Character codes
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_X  = 8'h58;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_X  = 8'h78;
   localparam logic [7:0] CHAR_LC_Z  = 8'h7A;

   // Digit value of a byte; NOT_DIGIT when it is no alphanumeric
   function automatic logic [RADIX_W-1:0] digit_of(input logic [7:0] c);
      logic [7:0] d;
      d = 8'(NOT_DIGIT);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = c - CHAR_ZERO;
      end else if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
         d = c - CHAR_UC_A + 8'(BASE_DEC);
      end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
         d = c - CHAR_LC_A + 8'(BASE_DEC);
      end
      return d[RADIX_W-1:0];
   endfunction

   // Space, TAB, LF, VT, FF or CR
   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic base_ok(input logic [RADIX_W-1:0] b);
      return (b >= BASE_MIN) && (b <= BASE_MAX);
   endfunction

endpackage

>>> src/a2u_csr.sv
// Configuration register file of the ASCII to unsigned parser (radix register).
module a2u_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output logic [a2u_pkg::RADIX_W-1:0] radix
);

   logic [a2u_pkg::RADIX_W-1:0] radix_ff;
   logic [a2u_pkg::RADIX_W-1:0] radix_in;
   logic                        write_hit;

   assign pready    = 1'b1;
   assign write_hit = psel && penable && pwrite && (paddr[2] == a2u_pkg::REG_RADIX);

   // Take the low bits of a write to the radix register
   always_comb begin
      radix_in = radix_ff;
      if (write_hit) begin
         radix_in = pwdata[a2u_pkg::RADIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= a2u_pkg::RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   // Read back
   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == a2u_pkg::REG_RADIX) begin
         prdata = {{(32 - a2u_pkg::RADIX_W){1'b0}}, radix_ff};
      end
   end

   assign radix = radix_ff;

endmodule

>>> src/a2u_core.sv
// Parse state and per-byte update of the ASCII to unsigned parser.
module a2u_core #(
   parameter int VALUE_WIDTH = 64,
   parameter int MAX_LENGTH  = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step_valid,
   input  logic [7:0]                   char_in,
   input  logic                         last_char,
   input  logic                         empty_string,
   input  logic [a2u_pkg::RADIX_W-1:0]  radix,
   output logic                         emit,
   output logic [VALUE_WIDTH-1:0]       result_value,
   output logic [a2u_pkg::OFFSET_W-1:0] result_offset,
   output a2u_pkg::flags_type           result_flags
);

   localparam int POS_W  = $clog2(MAX_LENGTH + 1);
   localparam int PROD_W = VALUE_WIDTH + 7;
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LENGTH);

   a2u_pkg::phase_type          phase_ff, phase_in, phase_upd;
   logic [VALUE_WIDTH-1:0]      acc_ff, acc_in, acc_upd;
   logic                        neg_ff, neg_in, neg_upd;
   logic                        ovf_ff, ovf_in, ovf_upd;
   logic                        seen_ff, seen_in, seen_upd;
   logic [a2u_pkg::RADIX_W-1:0] base_ff, base_in, base_upd;
   logic [POS_W-1:0]            pos_ff, pos_in, pos_upd;
   logic [POS_W-1:0]            stop_ff, stop_in, stop_upd;

   logic                        c_space, c_sign, c_zero, c_x;
   logic [a2u_pkg::RADIX_W-1:0] digit;
   logic                        r_auto, r_hex;
   logic                        do_start, start_zero, start_bad;
   logic [a2u_pkg::RADIX_W-1:0] start_base, take_base;
   logic                        do_take, digit_ok;
   logic [PROD_W-1:0]           prod;
   logic                        prod_ovf;
   logic [POS_W-1:0]            stop_next;
   logic                        byte_step;
   logic [VALUE_WIDTH-1:0]      value_sel;
   logic [POS_W+a2u_pkg::OFFSET_W-1:0] offset_wide;

   // Classify the byte
   assign c_space = a2u_pkg::is_space(char_in);
   assign c_sign  = (char_in == a2u_pkg::CHAR_PLUS) || (char_in == a2u_pkg::CHAR_MINUS);
   assign c_zero  = (char_in == a2u_pkg::CHAR_ZERO);
   assign c_x     = (char_in == a2u_pkg::CHAR_LC_X) || (char_in == a2u_pkg::CHAR_UC_X);
   assign digit   = a2u_pkg::digit_of(char_in);

   // Settle the base on the first byte of the number proper
   assign r_auto     = (radix == a2u_pkg::BASE_AUTO);
   assign r_hex      = (radix == a2u_pkg::BASE_HEX);
   assign do_start   = ((phase_ff == a2u_pkg::PH_SPACE) && !c_space && !c_sign) ||
                       (phase_ff == a2u_pkg::PH_START);
   assign start_zero = (r_auto || r_hex) && c_zero;
   assign start_bad  = !r_auto && !a2u_pkg::base_ok(radix);
   assign start_base = r_auto ? a2u_pkg::BASE_DEC : radix;
   assign take_base  = do_start ? start_base : base_ff;

   // Try the byte as a digit
   assign do_take  = (do_start && !start_zero && !start_bad) ||
                     ((phase_ff == a2u_pkg::PH_ZERO) && !c_x) ||
                     (phase_ff == a2u_pkg::PH_DIGITS);
   assign digit_ok = do_take && a2u_pkg::base_ok(take_base) && (digit < take_base);

   // Multiply-add; any bit above the value width means overflow
   assign prod     = PROD_W'(acc_ff) * PROD_W'(take_base) + PROD_W'(digit);
   assign prod_ovf = |prod[PROD_W-1:VALUE_WIDTH];

   assign stop_next = (pos_ff == POS_MAX) ? POS_MAX : pos_ff + 1'b1;
   assign byte_step = !empty_string;

   // Next phase
   always_comb begin
      phase_upd = phase_ff;
      if (byte_step) begin
         case (phase_ff)
            a2u_pkg::PH_SPACE: begin
               if (c_space) begin
                  phase_upd = a2u_pkg::PH_SPACE;
               end else if (c_sign) begin
                  phase_upd = a2u_pkg::PH_START;
               end else if (start_zero) begin
                  phase_upd = a2u_pkg::PH_ZERO;
               end else if (start_bad) begin
                  phase_upd = a2u_pkg::PH_BAD;
               end else begin
                  phase_upd = digit_ok ? a2u_pkg::PH_DIGITS : a2u_pkg::PH_DONE;
               end
            end
            a2u_pkg::PH_START: begin
               if (start_zero) begin
                  phase_upd = a2u_pkg::PH_ZERO;
               end else if (start_bad) begin
                  phase_upd = a2u_pkg::PH_BAD;
               end else begin
                  phase_upd = digit_ok ? a2u_pkg::PH_DIGITS : a2u_pkg::PH_DONE;
               end
            end
            a2u_pkg::PH_ZERO: begin
               if (c_x) begin
                  phase_upd = a2u_pkg::PH_DIGITS;
               end else begin
                  phase_upd = digit_ok ? a2u_pkg::PH_DIGITS : a2u_pkg::PH_DONE;
               end
            end
            a2u_pkg::PH_DIGITS: begin
               phase_upd = digit_ok ? a2u_pkg::PH_DIGITS : a2u_pkg::PH_DONE;
            end
            default: begin
               phase_upd = phase_ff;
            end
         endcase
      end
   end

   // Datapath update for one byte
   always_comb begin
      acc_upd  = acc_ff;
      neg_upd  = neg_ff;
      ovf_upd  = ovf_ff;
      seen_upd = seen_ff;
      base_upd = base_ff;
      pos_upd  = pos_ff;
      stop_upd = stop_ff;
      if (byte_step) begin
         if (pos_ff != POS_MAX) begin
            pos_upd = pos_ff + 1'b1;
         end
         if ((phase_ff == a2u_pkg::PH_SPACE) && c_sign) begin
            neg_upd = (char_in == a2u_pkg::CHAR_MINUS);
         end
         if (do_start && start_zero) begin
            seen_upd = 1'b1;
            stop_upd = stop_next;
            base_upd = r_auto ? a2u_pkg::BASE_OCT : a2u_pkg::BASE_HEX;
         end else if (do_start && !start_bad) begin
            base_upd = start_base;
         end
         if ((phase_ff == a2u_pkg::PH_ZERO) && c_x) begin
            base_upd = a2u_pkg::BASE_HEX;
         end
         if (digit_ok) begin
            acc_upd  = prod[VALUE_WIDTH-1:0];
            ovf_upd  = ovf_ff || prod_ovf;
            seen_upd = 1'b1;
            stop_upd = stop_next;
         end
      end
   end

   assign emit = step_valid && (empty_string || last_char);

   // Clear the string state after a result, else keep the update
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      seen_in  = seen_ff;
      base_in  = base_ff;
      pos_in   = pos_ff;
      stop_in  = stop_ff;
      if (emit) begin
         phase_in = a2u_pkg::PH_SPACE;
         acc_in   = '0;
         neg_in   = 1'b0;
         ovf_in   = 1'b0;
         seen_in  = 1'b0;
         base_in  = '0;
         pos_in   = '0;
         stop_in  = '0;
      end else if (step_valid) begin
         phase_in = phase_upd;
         acc_in   = acc_upd;
         neg_in   = neg_upd;
         ovf_in   = ovf_upd;
         seen_in  = seen_upd;
         base_in  = base_upd;
         pos_in   = pos_upd;
         stop_in  = stop_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= a2u_pkg::PH_SPACE;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         seen_ff  <= 1'b0;
         base_ff  <= '0;
         pos_ff   <= '0;
         stop_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         ovf_ff   <= ovf_in;
         seen_ff  <= seen_in;
         base_ff  <= base_in;
         pos_ff   <= pos_in;
         stop_ff  <= stop_in;
      end
   end

   // Form the result from the state after this byte
   always_comb begin
      if (phase_upd == a2u_pkg::PH_BAD) begin
         value_sel = '0;
      end else if (ovf_upd) begin
         value_sel = '1;
      end else if (neg_upd) begin
         value_sel = ~acc_upd + 1'b1;
      end else begin
         value_sel = acc_upd;
      end
   end

   assign offset_wide   = seen_upd ? {{a2u_pkg::OFFSET_W{1'b0}}, stop_upd} : '0;
   assign result_value  = value_sel;
   assign result_offset = offset_wide[a2u_pkg::OFFSET_W-1:0];
   assign result_flags.overflow     = ovf_upd;
   assign result_flags.bad_base     = (phase_upd == a2u_pkg::PH_BAD);
   assign result_flags.digits_found = seen_upd;

endmodule

>>> src/ascii_to_unsigned_parser.sv
// Top level of the ASCII to unsigned parser: input register, parse core, result register.
// An item that ends its string is held in the input register; its result is loaded into the result register.
// Throughput: one item per cycle unless stalled; the limit is the accumulator multiply-add loop.
// Back pressure on the result side stalls only items that end a string while it is full.
// Reset (synchronous, active high) clears the parse state, empties both registers and
// sets the radix register to 10.
module ascii_to_unsigned_parser #(
   parameter int VALUE_WIDTH = 64,
   parameter int MAX_LENGTH  = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   // Input channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_char_in,
   input  logic                         req_last_char,
   input  logic                         req_empty_string,
   // Result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [VALUE_WIDTH-1:0]       rsp_value,
   output logic [a2u_pkg::OFFSET_W-1:0] rsp_end_offset,
   output logic                         rsp_overflow,
   output logic                         rsp_bad_base,
   output logic                         rsp_digits_found,
   // Configuration port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [2:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   logic [a2u_pkg::RADIX_W-1:0]  radix;

   logic                         in_valid_ff, in_valid_in;
   logic [7:0]                   in_char_ff;
   logic                         in_last_ff;
   logic                         in_empty_ff;
   logic                         in_take;
   logic                         in_emits;
   logic                         out_free;
   logic                         fire;

   logic                         emit;
   logic [VALUE_WIDTH-1:0]       core_value;
   logic [a2u_pkg::OFFSET_W-1:0] core_offset;
   a2u_pkg::flags_type           core_flags;

   logic                         out_valid_ff, out_valid_in;
   logic [VALUE_WIDTH-1:0]       out_value_ff;
   logic [a2u_pkg::OFFSET_W-1:0] out_offset_ff;
   a2u_pkg::flags_type           out_flags_ff;

   a2u_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .radix   (radix)
   );

   // Advance the held item unless it ends a string and the result slot stays full
   assign in_emits  = in_last_ff || in_empty_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && (!in_emits || out_free);
   assign req_stall = in_valid_ff && !fire;
   assign in_take   = req_valid && !req_stall;

   assign in_valid_in = in_take || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Hold the accepted item
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_char_ff  <= req_char_in;
         in_last_ff  <= req_last_char;
         in_empty_ff <= req_empty_string;
      end
   end

   a2u_core #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_LENGTH  (MAX_LENGTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step_valid    (fire),
      .char_in       (in_char_ff),
      .last_char     (in_last_ff),
      .empty_string  (in_empty_ff),
      .radix         (radix),
      .emit          (emit),
      .result_value  (core_value),
      .result_offset (core_offset),
      .result_flags  (core_flags)
   );

   // Result register: load on emit, hold while stalled
   assign out_valid_in = emit || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_value_ff  <= core_value;
         out_offset_ff <= core_offset;
         out_flags_ff  <= core_flags;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_value        = out_value_ff;
   assign rsp_end_offset   = out_offset_ff;
   assign rsp_overflow     = out_flags_ff.overflow;
   assign rsp_bad_base     = out_flags_ff.bad_base;
   assign rsp_digits_found = out_flags_ff.digits_found;

endmodule
